// File: rtl/lzfu_pkg.sv
`timescale 1ns / 1ps

package lzfu_pkg;

	// Window geometry and preload length
	localparam int WinSize = 4096;
	localparam int WinAw   = 12;
	localparam int DictLen = 207;

	// Configuration port
	localparam int ApbAw = 3;
	localparam logic RegOutLimit = 1'b0;

	// Reference length bias: low nibble plus two
	localparam int LenBias = 2;

	typedef logic [WinAw-1:0] win_addr_t;

	typedef enum logic [1:0] {
		ST_DATA     = 2'd0,
		ST_END      = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_TRUNC    = 2'd3
	} status_t;

	// One write into the window memory
	typedef struct packed {
		logic      en;
		win_addr_t addr;
		logic [7:0] data;
	} win_wr_t;

	// Preloaded RTF dictionary, first character in the top byte
	localparam logic [8*DictLen-1:0] RTF_DICT = {
		"{\\rtf1\\ansi\\mac\\deff0\\deftab720",
		"{\\fonttbl;}",
		"{\\f0\\fnil \\froman \\fswiss \\fmodern \\fscript \\fdecor ",
		"MS Sans SerifSymbolArialTimes New RomanCourier",
		"{\\colortbl\\red0\\green0\\blue0\015\012",
		"\\par \\pard\\plain\\f0\\fs20\\b\\i\\u\\tab\\tx"
	};

	// Dictionary byte at position idx (idx below DictLen)
	function automatic logic [7:0] dict_byte(input logic [7:0] idx);
		return RTF_DICT[8*(DictLen-1-int'(idx)) +: 8];
	endfunction

endpackage

// File: rtl/lzfu_if.sv
`timescale 1ns / 1ps

// Compressed byte channel
interface lzfu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// Decompressed result channel
interface lzfu_out_if;
	logic                valid;
	logic                ready;
	logic [7:0]          out_byte;
	lzfu_pkg::status_t   status;
	logic                last_of_run;

	modport source (output valid, output out_byte, output status, output last_of_run,
		input ready);
	modport sink (input valid, input out_byte, input status, input last_of_run,
		output ready);
endinterface

// File: rtl/lzfu_rtf_decompressor_top.sv
`timescale 1ns / 1ps

// LZFu compressed RTF decompressor.
// The compressed channel takes one byte per transfer with a last mark on the
// final byte. The decompressed channel returns one result per transfer: a data
// byte, or a status (end marker, output overflow, truncated reference) that
// ends the stream; last_of_run marks the final result caused by an input byte.
// The APB port holds the output limit at byte address 0.
// Flag bytes, literals and reference high bytes are each handled as they are
// taken. A reference low byte starts a copy of the low nibble plus two bytes
// (2 to 17 bytes), read through the single read port of the 4096-byte window
// memory, which yields one source byte per cycle while the output is free. A
// literal or copied byte reaches the output through the output register.
// After reset the window is loaded with the dictionary and zeros in one pass
// over all 4096 bytes; no byte is taken during it. After an error, an end
// marker or the last byte, input bytes are taken and dropped until the next
// reset. When the receiver stalls, the output register holds its result and
// the block stops taking input and copying until it frees up.
module lzfu_rtf_decompressor_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lzfu_pkg::ApbAw-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	lzfu_in_if.sink                     compressed,
	lzfu_out_if.source                  decompressed
);
	import lzfu_pkg::*;

	logic [31:0] out_limit;
	logic        win_ready;
	win_addr_t   rd_addr;
	logic [7:0]  rd_data;
	win_wr_t     wr;

	lzfu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.out_limit (out_limit)
	);

	lzfu_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr      (wr),
		.ready   (win_ready)
	);

	lzfu_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.out_limit    (out_limit),
		.win_ready    (win_ready),
		.compressed   (compressed),
		.decompressed (decompressed),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.wr           (wr)
	);

	// No input is taken while the window is being loaded
	a_no_accept_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		!win_ready |-> !compressed.ready)
		else $error("input taken during window load");

	// The decoder never writes the window during the load pass
	a_no_write_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> win_ready)
		else $error("window write during load");

	// A status result carries a zero byte and closes its run
	a_status_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(decompressed.valid && (decompressed.status != ST_DATA)) |->
		(decompressed.last_of_run && (decompressed.out_byte == 8'd0)))
		else $error("status result malformed");

endmodule

// File: rtl/lzfu_cfg.sv
`timescale 1ns / 1ps

module lzfu_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lzfu_pkg::ApbAw-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [31:0]                 out_limit
);
	import lzfu_pkg::*;

	logic [31:0] out_limit_q;
	logic        hit;

	assign pready = 1'b1;
	assign hit    = (paddr[ApbAw-1:2] == RegOutLimit);

	// Take a write in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_limit_q <= 32'hFFFF_FFFF;
		end else if (psel && penable && pwrite && pready && hit) begin
			out_limit_q <= pwdata;
		end
	end

	// Read back the register, zero elsewhere
	assign prdata    = hit ? out_limit_q : 32'd0;
	assign out_limit = out_limit_q;

endmodule

// File: rtl/lzfu_window.sv
`timescale 1ns / 1ps

module lzfu_window (
	input  logic                clk,
	input  logic                arst_n,
	input  lzfu_pkg::win_addr_t rd_addr,
	output logic [7:0]          rd_data,
	input  lzfu_pkg::win_wr_t   wr,
	output logic                ready
);
	import lzfu_pkg::*;

	logic [7:0] mem [WinSize];
	logic [7:0] rd_q;
	logic       clr_busy_q;
	win_addr_t  clr_idx_q;
	logic       mw_en;
	win_addr_t  mw_addr;
	logic [7:0] mw_data;

	// Sweep the window after reset: dictionary first, zeros after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == WinAw'(WinSize - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Select the sweep or the decoder as the writer
	always_comb begin
		if (clr_busy_q) begin
			mw_en   = 1'b1;
			mw_addr = clr_idx_q;
			mw_data = (clr_idx_q < WinAw'(DictLen)) ? dict_byte(clr_idx_q[7:0]) : 8'd0;
		end else begin
			mw_en   = wr.en;
			mw_addr = wr.addr;
			mw_data = wr.data;
		end
	end

	// Write port and registered read; forward a same-cycle write to the reader
	always_ff @(posedge clk) begin
		if (mw_en) begin
			mem[mw_addr] <= mw_data;
		end
		if (mw_en && (mw_addr == rd_addr)) begin
			rd_q <= mw_data;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
	assign ready   = !clr_busy_q;

endmodule

// File: rtl/lzfu_ctrl.sv
`timescale 1ns / 1ps

module lzfu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         out_limit,
	input  logic                win_ready,
	lzfu_in_if.sink             compressed,
	lzfu_out_if.source          decompressed,
	output lzfu_pkg::win_addr_t rd_addr,
	input  logic [7:0]          rd_data,
	output lzfu_pkg::win_wr_t   wr
);
	import lzfu_pkg::*;

	typedef enum logic [1:0] {
		PH_FLAG = 2'd0,
		PH_ITEM = 2'd1,
		PH_LOW  = 2'd2
	} phase_t;

	typedef enum logic {
		S_IDLE,
		S_COPY
	} state_t;

	state_t     state_q;
	phase_t     phase_q;
	phase_t     adv_phase;
	logic [7:0] ctrl_q;
	logic [2:0] bit_q;
	logic [7:0] ref_high_q;
	win_addr_t  wp_q;
	logic [31:0] cnt_q;
	logic       halted_q;
	win_addr_t  src_q;
	logic [4:0] left_q;
	logic       end_after_q;

	logic       ov_q;
	logic [7:0] ob_q;
	status_t    os_q;
	logic       ol_q;

	logic        can_emit;
	logic        accept;
	logic        copy_fire;
	logic        cur_bit;
	logic [15:0] ref_word;
	win_addr_t   ref_off;
	logic [4:0]  ref_len;
	logic        lit_over;
	logic        ref_over;
	logic        lit_write;

	// Output register frees up when empty or being taken
	assign can_emit = !ov_q || decompressed.ready;
	assign compressed.ready = win_ready && (state_q == S_IDLE) && can_emit;
	assign accept = compressed.valid && compressed.ready;
	assign copy_fire = (state_q == S_COPY) && can_emit;

	// Decode the current control bit and a reference
	assign cur_bit  = ctrl_q[bit_q];
	assign ref_word = {ref_high_q, compressed.in_byte};
	assign ref_off  = ref_word[15:4];
	assign ref_len  = {1'b0, ref_word[3:0]} + 5'(LenBias);
	assign lit_over = (cnt_q >= out_limit);
	assign ref_over = (({1'b0, cnt_q} + 33'(ref_word[3:0]) + 33'd1) >= {1'b0, out_limit});
	assign adv_phase = (bit_q == 3'd7) ? PH_FLAG : PH_ITEM;

	assign lit_write = accept && !halted_q && (phase_q == PH_ITEM) && !cur_bit && !lit_over;

	// Read the next source byte ahead; hold the address while stalled
	always_comb begin
		if (state_q == S_COPY) begin
			rd_addr = can_emit ? (src_q + 1'b1) : src_q;
		end else begin
			rd_addr = ref_off;
		end
	end

	// Window write: a literal or a copied byte at the write position
	assign wr.en   = lit_write || copy_fire;
	assign wr.addr = wp_q;
	assign wr.data = (state_q == S_COPY) ? rd_data : compressed.in_byte;

	// Parser, copy sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_FLAG;
			ctrl_q      <= '0;
			bit_q       <= '0;
			ref_high_q  <= '0;
			wp_q        <= WinAw'(DictLen);
			cnt_q       <= '0;
			halted_q    <= 1'b0;
			src_q       <= '0;
			left_q      <= '0;
			end_after_q <= 1'b0;
			ov_q        <= 1'b0;
			ob_q        <= '0;
			os_q        <= ST_DATA;
			ol_q        <= 1'b0;
		end else begin
			if (decompressed.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && !halted_q) begin
						case (phase_q)
							PH_ITEM: begin
								if (!cur_bit) begin
									if (lit_over) begin
										ov_q     <= 1'b1;
										ob_q     <= '0;
										os_q     <= ST_OVERFLOW;
										ol_q     <= 1'b1;
										halted_q <= 1'b1;
									end else begin
										ov_q     <= 1'b1;
										ob_q     <= compressed.in_byte;
										os_q     <= ST_DATA;
										ol_q     <= 1'b1;
										wp_q     <= wp_q + 1'b1;
										cnt_q    <= cnt_q + 32'd1;
										bit_q    <= bit_q + 1'b1;
										phase_q  <= adv_phase;
										halted_q <= compressed.in_last;
									end
								end else if (compressed.in_last) begin
									ov_q     <= 1'b1;
									ob_q     <= '0;
									os_q     <= ST_TRUNC;
									ol_q     <= 1'b1;
									halted_q <= 1'b1;
								end else begin
									ref_high_q <= compressed.in_byte;
									phase_q    <= PH_LOW;
								end
							end
							PH_LOW: begin
								if (ref_off == wp_q) begin
									ov_q     <= 1'b1;
									ob_q     <= '0;
									os_q     <= ST_END;
									ol_q     <= 1'b1;
									halted_q <= 1'b1;
								end else if (ref_over) begin
									ov_q     <= 1'b1;
									ob_q     <= '0;
									os_q     <= ST_OVERFLOW;
									ol_q     <= 1'b1;
									halted_q <= 1'b1;
								end else begin
									src_q       <= ref_off;
									left_q      <= ref_len;
									end_after_q <= compressed.in_last;
									bit_q       <= bit_q + 1'b1;
									phase_q     <= adv_phase;
									state_q     <= S_COPY;
								end
							end
							default: begin
								ctrl_q   <= compressed.in_byte;
								bit_q    <= '0;
								phase_q  <= PH_ITEM;
								halted_q <= compressed.in_last;
							end
						endcase
					end
				end
				S_COPY: begin
					// Move one byte per free output slot
					if (can_emit) begin
						ov_q   <= 1'b1;
						ob_q   <= rd_data;
						os_q   <= ST_DATA;
						ol_q   <= (left_q == 5'd1);
						wp_q   <= wp_q + 1'b1;
						cnt_q  <= cnt_q + 32'd1;
						src_q  <= src_q + 1'b1;
						left_q <= left_q - 5'd1;
						if (left_q == 5'd1) begin
							state_q  <= S_IDLE;
							halted_q <= end_after_q;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign decompressed.valid       = ov_q;
	assign decompressed.out_byte    = ob_q;
	assign decompressed.status      = os_q;
	assign decompressed.last_of_run = ol_q;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import lzfu_pkg::*;

	localparam int SettleCycles = 40;
	localparam logic [ApbAw-1:0] LimitAddr = ApbAw'({RegOutLimit, 2'b00});

	// RTF dictionary as it sits in the window after reset
	localparam logic [8*DictLen-1:0] RtfText = {
		"{\\rtf1\\ansi\\mac\\deff0\\deftab720",
		"{\\fonttbl;}",
		"{\\f0\\fnil \\froman \\fswiss \\fmodern \\fscript \\fdecor ",
		"MS Sans SerifSymbolArialTimes New RomanCourier",
		"{\\colortbl\\red0\\green0\\blue0\015\012",
		"\\par \\pard\\plain\\f0\\fs20\\b\\i\\u\\tab\\tx"
	};

	typedef enum logic [1:0] {
		EXPECT_FLAG = 2'd0,
		EXPECT_ITEM = 2'd1,
		EXPECT_LOW  = 2'd2
	} dec_phase_t;

	typedef struct packed {
		logic [7:0] data;
		status_t    status;
		logic       fin;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [ApbAw-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lzfu_in_if  cmp_ch ();
	lzfu_out_if dcm_ch ();

	lzfu_rtf_decompressor_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.compressed   (cmp_ch),
		.decompressed (dcm_ch)
	);

	// Decoder copy: window, pointers and limit
	logic [7:0]  win_copy [WinSize];
	logic [11:0] wpos;
	dec_phase_t  dec_phase;
	logic [7:0]  ctrl;
	logic [3:0]  bit_idx;
	logic [7:0]  ref_hi;
	logic [31:0] count;
	logic        halted;
	logic [31:0] limit;

	result_t results_due [$];
	int      errors;
	int      bytes_in;
	bit      calm;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Push one byte into the window and clear the slot after it
	function automatic void store_out(input logic [7:0] b);
		win_copy[wpos] = b;
		wpos = wpos + 12'd1;
		win_copy[wpos] = 8'h00;
		count = count + 32'd1;
	endfunction

	function automatic void stop_with(input status_t st);
		results_due.push_back('{data: 8'h00, status: st, fin: 1'b1});
		halted = 1'b1;
	endfunction

	function automatic void next_bit();
		bit_idx = bit_idx + 4'd1;
		if (bit_idx >= 4'd8) begin
			bit_idx = 4'd0;
			dec_phase = EXPECT_FLAG;
		end else begin
			dec_phase = EXPECT_ITEM;
		end
	endfunction

	// Work out the decompressed bytes one compressed byte causes
	function automatic void decode_byte(input logic [7:0] b, input logic fin);
		logic [15:0] code;
		logic [11:0] src;
		logic [7:0]  byte_v;
		logic [63:0] reach;
		int          len;
		if (halted)
			return;
		case (dec_phase)
			EXPECT_ITEM: begin
				if (!ctrl[bit_idx[2:0]]) begin
					if (count >= limit) begin
						stop_with(ST_OVERFLOW);
						return;
					end
					store_out(b);
					results_due.push_back('{data: b, status: ST_DATA, fin: 1'b1});
					next_bit();
				end else begin
					if (fin) begin
						stop_with(ST_TRUNC);
						return;
					end
					ref_hi = b;
					dec_phase = EXPECT_LOW;
					return;
				end
			end
			EXPECT_LOW: begin
				code = {ref_hi, b};
				len = int'(code[3:0]) + LenBias;
				src = code[15:4];
				if (src == wpos) begin
					stop_with(ST_END);
					return;
				end
				reach = {32'd0, count} + 64'(len) - 64'd1;
				if (reach >= {32'd0, limit}) begin
					stop_with(ST_OVERFLOW);
					return;
				end
				for (int i = 0; i < len; i++) begin
					byte_v = win_copy[src];
					store_out(byte_v);
					results_due.push_back('{data: byte_v, status: ST_DATA, fin: (i == len - 1)});
					src = src + 12'd1;
				end
				next_bit();
			end
			default: begin
				ctrl = b;
				bit_idx = 4'd0;
				dec_phase = EXPECT_ITEM;
			end
		endcase
		if (fin)
			halted = 1'b1;
	endfunction

	// Mostly short gaps, a few long ones, none while calm
	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Source offset for a reference that never points at the write slot
	function automatic logic [11:0] pick_offset();
		logic [11:0] off;
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			off = wpos - 12'($urandom_range(1, 40));
		else if (r < 6)
			off = 12'($urandom_range(0, DictLen - 1));
		else if (r < 7)
			off = 12'($urandom_range(4080, 4095));
		else
			off = 12'($urandom_range(0, 4095));
		if (off == wpos)
			off = off + 12'd1;
		return off;
	endfunction

	// Result sink: random stalls, none while calm
	initial begin : result_sink
		int hold;
		hold = 0;
		dcm_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				dcm_ch.ready <= 1'b0;
				hold--;
			end else begin
				dcm_ch.ready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					hold = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
						: $urandom_range(6, 30);
			end
		end
	end

	// Compare each result transfer with the oldest expected one
	always @(posedge clk) begin
		result_t want;
		if (arst_n && dcm_ch.valid && dcm_ch.ready) begin
			if (results_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual byte %02h status %0d",
					$time, dcm_ch.out_byte, dcm_ch.status);
			end else begin
				want = results_due.pop_front();
				if (dcm_ch.out_byte !== want.data) begin
					errors++;
					$display("%0t: out_byte expected %02h actual %02h",
						$time, want.data, dcm_ch.out_byte);
				end
				if (dcm_ch.status !== want.status) begin
					errors++;
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, dcm_ch.status);
				end
				if (dcm_ch.last_of_run !== want.fin) begin
					errors++;
					$display("%0t: last_of_run expected %0b actual %0b",
						$time, want.fin, dcm_ch.last_of_run);
				end
			end
		end
	end

	// Send one compressed byte and wait for its transfer
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		cmp_ch.valid <= 1'b1;
		cmp_ch.in_byte <= b;
		cmp_ch.in_last <= fin;
		do @(posedge clk); while (!cmp_ch.ready);
		decode_byte(b, fin);
		bytes_in++;
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		gap = idle_len();
		if (gap > 0) begin
			cmp_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_ref(input logic [11:0] off, input logic [3:0] len_code,
		input logic fin = 1'b0);
		send_byte(off[11:4], 1'b0);
		send_byte({off[3:0], len_code}, fin);
	endtask

	// Hold input until every expected result is out, then let the block go quiet
	task automatic settle();
		cmp_ch.valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Write the output limit, then read it back
	task automatic set_out_limit(input logic [31:0] value);
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LimitAddr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		limit = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== value) begin
			errors++;
			$display("%0t: out_limit read expected %08h actual %08h", $time, value, got);
		end
	endtask

	// Next well-formed entry: flag, literal or reference as the decoder expects
	task automatic send_random_entry();
		int r;
		if (dec_phase != EXPECT_ITEM) begin
			r = $urandom_range(0, 9);
			if (r < 3)
				send_byte(8'hFF, 1'b0);
			else if (r < 4)
				send_byte(8'h00, 1'b0);
			else
				send_byte(8'($urandom), 1'b0);
		end else if (ctrl[bit_idx[2:0]]) begin
			send_ref(pick_offset(),
				$urandom_range(0, 1) ? 4'hF : 4'($urandom_range(0, 15)));
		end else begin
			send_byte(8'($urandom), 1'b0);
		end
	endtask

	// Advance the stream until the next entry is of the wanted kind
	task automatic advance_to(input logic want_ref);
		while (!(dec_phase == EXPECT_ITEM && ctrl[bit_idx[2:0]] == want_ref)) begin
			if (dec_phase != EXPECT_ITEM)
				send_byte(want_ref ? 8'hFF : 8'h00, 1'b0);
			else
				send_random_entry();
		end
	endtask

	// Zero limit: only bytes that produce nothing go in, then the limit opens
	task automatic test_zero_limit();
		set_out_limit(32'd0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		settle();
		set_out_limit(32'hFFFF_FFFF);
	endtask

	// References at the window edges and over fresh output, then literal extremes
	task automatic test_directed_stream();
		logic [7:0] lits [8];
		lits = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};
		send_byte(8'h0F, 1'b0);
		send_ref(12'hFFF, 4'h0);
		send_ref(12'hFF8, 4'hF);
		send_ref(12'(DictLen - 1), 4'h5);
		send_ref(wpos - 12'd1, 4'hF);
		send_ref(wpos - 12'd2, 4'h3);
		send_ref(12'h800, 4'h7);
		send_ref(12'h123, 4'hA);
		send_byte(8'h00, 1'b0);
		foreach (lits[i])
			send_byte(lits[i], 1'b0);
	endtask

	// Long random stream, with a limit change halfway
	task automatic test_random_stream();
		int target;
		target = bytes_in + 190;
		while (bytes_in < target) begin
			send_random_entry();
			if ($urandom_range(0, 59) == 0)
				settle();
		end
		settle();
		set_out_limit(count + 32'd4000 + 32'($urandom_range(0, 1000)));
		target = bytes_in + 190;
		while (bytes_in < target) begin
			send_random_entry();
			if ($urandom_range(0, 59) == 0)
				settle();
		end
	endtask

	// End the stream one way, picked at random
	task automatic test_stream_end();
		case ($urandom_range(0, 6))
			0: begin
				advance_to(1'b0);
				send_byte(8'($urandom), 1'b1);
			end
			1: begin
				advance_to(1'b1);
				send_ref(pick_offset(), 4'($urandom_range(0, 15)), 1'b1);
			end
			2: begin
				while (dec_phase != EXPECT_FLAG)
					send_random_entry();
				send_byte(8'($urandom), 1'b1);
			end
			3: begin
				advance_to(1'b1);
				send_byte(8'($urandom), 1'b1);
			end
			4: begin
				advance_to(1'b1);
				send_ref(wpos, 4'($urandom_range(0, 15)));
			end
			5: begin
				// a copy that lands exactly on the limit passes, the next output overflows
				advance_to(1'b1);
				settle();
				set_out_limit(count + 32'd17);
				send_ref(pick_offset(), 4'hF);
				while (!halted)
					send_random_entry();
			end
			default: begin
				advance_to(1'b0);
				settle();
				set_out_limit(count);
				send_byte(8'($urandom), 1'b0);
			end
		endcase
	endtask

	// Once halted, bytes are dropped and nothing comes out
	task automatic test_after_halt();
		repeat (8)
			send_byte(8'($urandom), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cmp_ch.valid <= 1'b0;
		cmp_ch.in_byte <= 8'h00;
		cmp_ch.in_last <= 1'b0;
		errors = 0;
		bytes_in = 0;
		calm = 1'b0;

		// window holds the dictionary, then zeros
		for (int i = 0; i < WinSize; i++)
			win_copy[i] = (i < DictLen) ? RtfText[8*(DictLen-1-i) +: 8] : 8'h00;
		wpos = 12'(DictLen);
		dec_phase = EXPECT_FLAG;
		ctrl = 8'h00;
		bit_idx = 4'd0;
		ref_hi = 8'h00;
		count = 32'd0;
		halted = 1'b0;
		limit = 32'hFFFF_FFFF;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_zero_limit();
		test_directed_stream();
		test_random_stream();
		test_stream_end();
		test_after_halt();

		// drain what is left, with a bound
		cmp_ch.valid <= 1'b0;
		for (int w = 0; w < 20000 && results_due.size() != 0; w++)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		if (results_due.size() != 0) begin
			errors++;
			$display("%0t: %0d results expected but never seen", $time, results_due.size());
		end
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/lzfu_pkg.sv
rtl/lzfu_if.sv
rtl/lzfu_cfg.sv
rtl/lzfu_window.sv
rtl/lzfu_ctrl.sv
rtl/lzfu_rtf_decompressor_top.sv
verif/tb.sv
